>>> rtl/pse_pkg.sv
package pse_pkg;

  localparam int CoordBits = 24;
  localparam int NormIters = 16;
  localparam int HwBits    = 23;
  localparam int IdxBits   = 32;
  localparam int CfgBits   = 32;
  localparam int CfgIdxBits = 2;

  localparam logic [CfgIdxBits-1:0] RegHalfWidth  = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegColor      = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegBaseVertex = 2'd2;

  localparam logic KindVertex   = 1'b0;
  localparam logic KindTriangle = 1'b1;

  // Difference of two coordinates needs one bit more.
  localparam int DiffBits = CoordBits + 1;

  // Classified job handed from the front to the back.
  typedef struct packed {
    logic                        do_norm;   // offset comes from a segment
    logic                        two_pts;   // emit the current point as well
    logic signed [CoordBits-1:0] p0x;
    logic signed [CoordBits-1:0] p0y;
    logic signed [CoordBits-1:0] p1x;
    logic signed [CoordBits-1:0] p1y;
    logic signed [DiffBits-1:0]  vx;
    logic signed [DiffBits-1:0]  vy;
    logic [IdxBits-1:0]          ord0;
  } job_t;

endpackage

>>> rtl/pse_front.sv
module pse_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               stall_o,
  input  logic signed [pse_pkg::CoordBits-1:0] px_i,
  input  logic signed [pse_pkg::CoordBits-1:0] py_i,
  input  logic                               final_point_i,
  output logic                               job_valid_o,
  input  logic                               job_stall_i,
  output pse_pkg::job_t                      job_o
);
  import pse_pkg::*;

  logic signed [CoordBits-1:0] prev_x_q, prev_y_q;
  logic [IdxBits-1:0]          prev_ord_q;
  logic                        have_prev_q;
  logic                        jv_q;
  job_t                        job_q;
  logic                        acc;

  assign stall_o     = jv_q && job_stall_i;
  assign acc         = valid_i && !stall_o;
  assign job_valid_o = jv_q;
  assign job_o       = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_ord_q  <= '0;
      have_prev_q <= 1'b0;
      jv_q        <= 1'b0;
    end else begin
      if (jv_q && !job_stall_i) begin
        jv_q <= 1'b0;
      end
      if (acc) begin
        if (!have_prev_q && !final_point_i) begin
          prev_x_q    <= px_i;
          prev_y_q    <= py_i;
          prev_ord_q  <= '0;
          have_prev_q <= 1'b1;
        end else begin
          jv_q <= 1'b1;
          if (final_point_i) begin
            prev_x_q    <= '0;
            prev_y_q    <= '0;
            prev_ord_q  <= '0;
            have_prev_q <= 1'b0;
          end else begin
            prev_x_q   <= px_i;
            prev_y_q   <= py_i;
            prev_ord_q <= prev_ord_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      job_q.do_norm <= have_prev_q;
      job_q.two_pts <= have_prev_q && final_point_i;
      job_q.p0x     <= have_prev_q ? prev_x_q : px_i;
      job_q.p0y     <= have_prev_q ? prev_y_q : py_i;
      job_q.p1x     <= px_i;
      job_q.p1y     <= py_i;
      job_q.vx      <= DiffBits'(px_i) - DiffBits'(prev_x_q);
      job_q.vy      <= DiffBits'(py_i) - DiffBits'(prev_y_q);
      job_q.ord0    <= have_prev_q ? prev_ord_q : '0;
    end
  end
endmodule

>>> rtl/pse_norm.sv
module pse_norm (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [pse_pkg::DiffBits-1:0] vx_i,
  input  logic signed [pse_pkg::DiffBits-1:0] vy_i,
  input  logic [pse_pkg::HwBits-1:0]          hw_i,
  output logic                                done_o,
  output logic signed [pse_pkg::HwBits:0]     dx_o,
  output logic signed [pse_pkg::HwBits:0]     dy_o
);
  import pse_pkg::*;

  localparam int SBits = 2 * NormIters;
  localparam int NBits = HwBits + NormIters + 2;
  localparam int QBits = HwBits + 1;
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StNorm = 3'd1;
  localparam logic [2:0] StSq   = 3'd2;
  localparam logic [2:0] StRoot = 3'd3;
  localparam logic [2:0] StMul  = 3'd4;
  localparam logic [2:0] StDiv  = 3'd5;

  logic [2:0]             st_q;
  logic [DiffBits-1:0]    a_q, b_q;
  logic                   negx_q, posy_q;
  logic [SBits-1:0]       s_q;
  logic [NormIters-1:0]   r_q, l_q;
  logic [5:0]             cnt_q;
  logic [NBits-1:0]       nx_q, ny_q, remx_q, remy_q;
  logic [QBits-1:0]       qx_q, qy_q;
  logic                   zero_q;
  logic [DiffBits-1:0]    m;
  logic [NormIters-1:0]   trial;
  logic [SBits-1:0]       tsq, rsq;
  logic [NBits-1:0]       dv, rx, ry;

  assign m     = (a_q > b_q) ? a_q : b_q;
  assign trial = r_q | (NormIters'(1) << cnt_q[4:0]);
  assign tsq   = SBits'(trial) * SBits'(trial);
  assign rsq   = SBits'(r_q) * SBits'(r_q);
  assign dv    = NBits'({l_q, 1'b0});
  assign rx    = {remx_q[NBits-2:0], nx_q[NBits-1]};
  assign ry    = {remy_q[NBits-2:0], ny_q[NBits-1]};

  assign done_o = (st_q == StDiv) && (cnt_q == 6'd0);
  assign dx_o   = zero_q ? '0 : (posy_q ? -$signed({1'b0, qx_q[QBits-2:0]})
                                        : $signed({1'b0, qx_q[QBits-2:0]}));
  assign dy_o   = zero_q ? $signed({1'b0, hw_i})
                         : (negx_q ? -$signed({1'b0, qy_q[QBits-2:0]})
                                   : $signed({1'b0, qy_q[QBits-2:0]}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
    end else begin
      case (st_q)
        StIdle: if (start_i) st_q <= StNorm;
        StNorm: begin
          if (m == '0) st_q <= StDiv;
          else if (m < (DiffBits'(1) << (NormIters - 2))) st_q <= StNorm;
          else if (m >= (DiffBits'(1) << (NormIters - 1))) st_q <= StNorm;
          else st_q <= StSq;
        end
        StSq:   st_q <= StRoot;
        StRoot: if (cnt_q == 6'd0) st_q <= StMul;
        StMul:  st_q <= StDiv;
        StDiv:  if (cnt_q == 6'd0) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

  // One shift of the pair per cycle during normalization, one root bit and
  // one quotient bit per cycle after that.
  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: begin
        a_q    <= vx_i[DiffBits-1] ? DiffBits'(-vx_i) : DiffBits'(vx_i);
        b_q    <= vy_i[DiffBits-1] ? DiffBits'(-vy_i) : DiffBits'(vy_i);
        negx_q <= vx_i[DiffBits-1];
        posy_q <= !vy_i[DiffBits-1] && (vy_i != '0);
      end
      StNorm: begin
        zero_q <= (m == '0);
        cnt_q  <= 6'd0;
        if (m != '0 && m < (DiffBits'(1) << (NormIters - 2))) begin
          a_q <= a_q << 1;
          b_q <= b_q << 1;
        end else if (m >= (DiffBits'(1) << (NormIters - 1))) begin
          a_q <= a_q >> 1;
          b_q <= b_q >> 1;
        end
      end
      StSq: begin
        s_q   <= SBits'(a_q[NormIters-1:0]) * SBits'(a_q[NormIters-1:0])
               + SBits'(b_q[NormIters-1:0]) * SBits'(b_q[NormIters-1:0]);
        r_q   <= '0;
        cnt_q <= 6'(NormIters - 1);
      end
      StRoot: begin
        if (tsq <= s_q) r_q <= trial;
        if (cnt_q != 6'd0) cnt_q <= cnt_q - 1'b1;
      end
      StMul: begin
        l_q    <= ((s_q - rsq) > SBits'(r_q)) ? r_q + 1'b1 : r_q;
        nx_q   <= NBits'({hw_i, 1'b0}) * NBits'(b_q[NormIters-1:0])
                + NBits'((s_q - rsq) > SBits'(r_q) ? r_q + 1'b1 : r_q);
        ny_q   <= NBits'({hw_i, 1'b0}) * NBits'(a_q[NormIters-1:0])
                + NBits'((s_q - rsq) > SBits'(r_q) ? r_q + 1'b1 : r_q);
        remx_q <= '0;
        remy_q <= '0;
        qx_q   <= '0;
        qy_q   <= '0;
        cnt_q  <= 6'(NBits);
      end
      StDiv: begin
        if (cnt_q != 6'd0) begin
          cnt_q <= cnt_q - 1'b1;
          nx_q  <= nx_q << 1;
          ny_q  <= ny_q << 1;
          remx_q <= (rx >= dv) ? rx - dv : rx;
          remy_q <= (ry >= dv) ? ry - dv : ry;
          qx_q  <= {qx_q[QBits-2:0], rx >= dv};
          qy_q  <= {qy_q[QBits-2:0], ry >= dv};
        end
      end
      default: ;
    endcase
  end
endmodule

>>> rtl/pse_back.sv
module pse_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 job_valid_i,
  output logic                                 job_stall_o,
  input  pse_pkg::job_t                        job_i,
  input  logic [pse_pkg::HwBits-1:0]           hw_i,
  input  logic [pse_pkg::IdxBits-1:0]          color_i,
  input  logic [pse_pkg::IdxBits-1:0]          base_i,
  output logic                                 valid_o,
  input  logic                                 stall_i,
  output logic                                 kind_o,
  output logic signed [pse_pkg::CoordBits-1:0] vx_o,
  output logic signed [pse_pkg::CoordBits-1:0] vy_o,
  output logic [pse_pkg::IdxBits-1:0]          vcolor_o,
  output logic [pse_pkg::IdxBits-1:0]          idx_a_o,
  output logic [pse_pkg::IdxBits-1:0]          idx_b_o,
  output logic [pse_pkg::IdxBits-1:0]          idx_c_o,
  output logic                                 run_end_o
);
  import pse_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StWait = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;
  localparam int EBits = CoordBits + 2;

  logic [1:0]            st_q;
  job_t                  j_q;
  logic [2:0]            k_q, last_q;
  logic signed [HwBits:0] dx_q, dy_q, ndx, ndy;
  logic                  ndone;
  logic                  pt, sub, tri_b, tri_e;
  logic signed [CoordBits-1:0] bx, by;
  logic signed [EBits-1:0] ex, ey;
  logic [IdxBits-1:0]    ord, p1;

  pse_norm u_norm (
    .clk_i, .rst_ni,
    .start_i (st_q == StIdle && job_valid_i && job_i.do_norm),
    .vx_i    (job_i.vx),
    .vy_i    (job_i.vy),
    .hw_i,
    .done_o  (ndone),
    .dx_o    (ndx),
    .dy_o    (ndy)
  );

  assign job_stall_o = (st_q != StIdle);

  // Slot k: 0/1 vertices of point 0, its triangles (none at ord0 0), point 1, triangles.
  always_comb begin
    pt    = j_q.do_norm ? (k_q >= 3'd4 || (j_q.ord0 == '0 && k_q >= 3'd2)) : 1'b0;
    sub   = 1'b0;
    tri_b = 1'b0;
    tri_e = 1'b0;
    if (j_q.ord0 == '0) begin
      sub   = (k_q == 3'd0) || (k_q == 3'd2);
      tri_b = (k_q == 3'd4);
      tri_e = (k_q == 3'd5);
    end else begin
      sub   = (k_q == 3'd0) || (k_q == 3'd4);
      tri_b = (k_q == 3'd2) || (k_q == 3'd6);
      tri_e = (k_q == 3'd3) || (k_q == 3'd7);
    end
    bx  = pt ? j_q.p1x : j_q.p0x;
    by  = pt ? j_q.p1y : j_q.p0y;
    ex  = sub ? EBits'(bx) - EBits'(dx_q) : EBits'(bx) + EBits'(dx_q);
    ey  = sub ? EBits'(by) - EBits'(dy_q) : EBits'(by) + EBits'(dy_q);
    ord = pt ? j_q.ord0 + 1'b1 : j_q.ord0;
    p1  = base_i + {ord[IdxBits-2:0] - 1'b1, 1'b0};
  end

  function automatic logic signed [CoordBits-1:0] sat(input logic signed [EBits-1:0] v);
    logic signed [EBits-1:0] hi;
    hi = EBits'({1'b0, {(CoordBits-1){1'b1}}});
    if (v > hi) sat = hi[CoordBits-1:0];
    else if (v < -hi - 1) sat = {1'b1, {(CoordBits-1){1'b0}}};
    else sat = v[CoordBits-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      valid_o <= 1'b0;
      k_q     <= '0;
    end else begin
      case (st_q)
        StIdle: if (job_valid_i) st_q <= job_i.do_norm ? StWait : StEmit;
        StWait: if (ndone) st_q <= StEmit;
        StEmit: begin
          if (!valid_o || !stall_i) begin
            valid_o <= 1'b1;
            if (k_q == last_q) begin
              st_q <= StIdle;
              k_q  <= '0;
            end else begin
              k_q <= k_q + 1'b1;
            end
          end
        end
        default: st_q <= StIdle;
      endcase
      if (valid_o && !stall_i && !(st_q == StEmit)) valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && job_valid_i) begin
      j_q    <= job_i;
      dx_q   <= '0;
      dy_q   <= $signed({1'b0, hw_i});
      last_q <= !job_i.do_norm ? 3'd1
              : (job_i.two_pts ? (job_i.ord0 == '0 ? 3'd5 : 3'd7)
                               : (job_i.ord0 == '0 ? 3'd1 : 3'd3));
    end
    if (st_q == StWait && ndone) begin
      dx_q <= ndx;
      dy_q <= ndy;
    end
    if (st_q == StEmit && (!valid_o || !stall_i)) begin
      run_end_o <= (k_q == last_q);
      if (tri_b || tri_e) begin
        kind_o   <= KindTriangle;
        vx_o     <= '0;
        vy_o     <= '0;
        vcolor_o <= '0;
        idx_a_o  <= tri_b ? p1 : p1 + 32'd1;
        idx_b_o  <= tri_b ? p1 + 32'd1 : p1 + 32'd2;
        idx_c_o  <= tri_b ? p1 + 32'd2 : p1 + 32'd3;
      end else begin
        kind_o   <= KindVertex;
        vx_o     <= sat(ex);
        vy_o     <= sat(ey);
        vcolor_o <= color_i;
        idx_a_o  <= '0;
        idx_b_o  <= '0;
        idx_c_o  <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StEmit |-> k_q <= last_q) else $error("slot beyond last");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(kind_o)) else $error("result dropped");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StWait |-> job_stall_o) else $error("job taken while busy");
`endif
endmodule

>>> rtl/polyline_stroke_expand.sv
// Polyline stroke expansion: two vertices per point, two triangles per segment.
// A held point's results follow once the next point is taken: a lone point skips
// the normaliser and a zero-length segment skips all but its first step; else it
// runs normalisation (one shift per cycle, up to 14 shifts), the bit-serial root
// (16 steps) and the restoring divide (41 steps). The front can take the next
// point while the back works; reset (asynchronous, active low) clears the control
// and configuration registers and the held point.
module polyline_stroke_expand (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pse_pkg::CfgIdxBits-1:0]       cfg_idx_i,
  input  logic [pse_pkg::CfgBits-1:0]          cfg_data_i,
  input  logic                                 valid_i,
  output logic                                 stall_o,
  input  logic signed [pse_pkg::CoordBits-1:0] px_i,
  input  logic signed [pse_pkg::CoordBits-1:0] py_i,
  input  logic                                 final_point_i,
  output logic                                 valid_o,
  input  logic                                 stall_i,
  output logic                                 kind_o,
  output logic signed [pse_pkg::CoordBits-1:0] vx_o,
  output logic signed [pse_pkg::CoordBits-1:0] vy_o,
  output logic [pse_pkg::IdxBits-1:0]          vcolor_o,
  output logic [pse_pkg::IdxBits-1:0]          idx_a_o,
  output logic [pse_pkg::IdxBits-1:0]          idx_b_o,
  output logic [pse_pkg::IdxBits-1:0]          idx_c_o,
  output logic                                 run_end_o
);
  import pse_pkg::*;

  // Configuration registers, to be written only while the block is idle; the block does not enforce this.
  logic [HwBits-1:0]  hw_q;
  logic [IdxBits-1:0] color_q, base_q;
  logic               jv, js;
  job_t               job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q    <= '0;
      color_q <= '0;
      base_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegHalfWidth:  hw_q    <= cfg_data_i[HwBits-1:0];
        RegColor:      color_q <= cfg_data_i;
        RegBaseVertex: base_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The front holds the previous point and classifies each word; the job
  // register between the parts lets the front take a word while the back works.
  pse_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .px_i, .py_i, .final_point_i,
    .job_valid_o (jv), .job_stall_i (js), .job_o (job)
  );

  pse_back u_back (
    .clk_i, .rst_ni, .job_valid_i (jv), .job_stall_o (js), .job_i (job),
    .hw_i (hw_q), .color_i (color_q), .base_i (base_q),
    .valid_o, .stall_i, .kind_o, .vx_o, .vy_o, .vcolor_o,
    .idx_a_o, .idx_b_o, .idx_c_o, .run_end_o
  );
endmodule
